// File: sv/ssmm_pkg.sv
// Shared types, codes and constants of the slot select memory mapper decoder.
package ssmm_pkg;

    localparam int RAM_ADDRESS_BITS = 22;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int TARGET_W   = 4;
    localparam int TADDR_W    = 22;
    localparam int ROM_SIZE_W = 17;
    localparam int RAM_SIZE_W = 23;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 23;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    localparam logic [TADDR_W-1:0] RAM_MASK = TADDR_W'((64'd1 << RAM_ADDRESS_BITS) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_GEN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIOS_SIZE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_ROM_SIZE = 8'd3;

    localparam logic [ROM_SIZE_W-1:0] BIOS_SIZE_RESET    = 17'd32768;
    localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_RESET     = 23'd65536;
    localparam logic [ROM_SIZE_W-1:0] SUB_ROM_SIZE_RESET = 17'd0;

    localparam logic [1:0] SLOT_BIOS      = 2'd0;
    localparam logic [1:0] SLOT_CART      = 2'd1;
    localparam logic [1:0] SLOT_EXPANSION = 2'd2;
    localparam logic [1:0] SLOT_THREE     = 2'd3;

    localparam logic [1:0] SUB_SLOT_RAM     = 2'd0;
    localparam logic [1:0] SUB_SLOT_SUB_ROM = 2'd1;

    localparam logic [ADDR_W-1:0] ADDR_SECONDARY_REG = 16'hffff;

    localparam logic [7:0] PORT_VIDEO_FIRST = 8'h98;
    localparam logic [7:0] PORT_VIDEO_LAST  = 8'h9b;
    localparam logic [7:0] PORT_SOUND_SEL   = 8'ha0;
    localparam logic [7:0] PORT_SOUND_WRITE = 8'ha1;
    localparam logic [7:0] PORT_SOUND_READ  = 8'ha2;
    localparam logic [7:0] PORT_PRIMARY     = 8'ha8;
    localparam logic [7:0] PORT_KEY_READ    = 8'ha9;
    localparam logic [7:0] PORT_KEY_WRITE   = 8'haa;
    localparam logic [7:0] PORT_SEGMENT     = 8'hfc;

    localparam logic [DATA_W-1:0] OPEN_BUS = 8'hff;

    typedef enum logic [OP_W-1:0] {
        OP_MEM_READ  = 2'd0,
        OP_MEM_WRITE = 2'd1,
        OP_IO_IN     = 2'd2,
        OP_IO_OUT    = 2'd3
    } ssmm_op_t;

    typedef enum logic [TARGET_W-1:0] {
        TGT_NONE       = 4'd0,
        TGT_BIOS       = 4'd1,
        TGT_CART       = 4'd2,
        TGT_EXPANSION  = 4'd3,
        TGT_RAM        = 4'd4,
        TGT_SUB_ROM    = 4'd5,
        TGT_VIDEO      = 4'd6,
        TGT_SOUND_SEL  = 4'd7,
        TGT_SOUND_DATA = 4'd8,
        TGT_KEYBOARD   = 4'd9
    } ssmm_target_t;

    typedef struct packed {
        logic                  second_gen;
        logic [ROM_SIZE_W-1:0] bios_size;
        logic [RAM_SIZE_W-1:0] ram_size;
        logic [ROM_SIZE_W-1:0] sub_rom_size;
    } ssmm_cfg_t;

    typedef struct packed {
        logic [3:0][1:0] primary;
        logic [3:0][1:0] secondary;
        logic [3:0][7:0] segment;
    } ssmm_state_t;

    typedef struct packed {
        logic              wr_primary;
        logic              wr_secondary;
        logic              wr_segment;
        logic [1:0]        seg_index;
        logic [DATA_W-1:0] value;
    } ssmm_update_t;

    typedef struct packed {
        ssmm_target_t       target;
        logic [TADDR_W-1:0] target_address;
        logic [DATA_W-1:0]  write_data;
        logic [DATA_W-1:0]  internal_data;
    } ssmm_result_t;

endpackage

// File: sv/slot_select_memory_mapper_decoder_unit.sv
// Top level of the slot select memory mapper decoder.
// Each item is one CPU access (memory read or write, I/O in or out) and
// yields exactly one result item naming the device that serves it, the
// address inside that device, the forwarded write data and, for reads
// that no device takes, the register readback or open-bus value. Items pass
// an input register, one level of decode logic over the slot and segment
// registers, and a result register; one item is taken every cycle as long as
// the result side keeps up, and the result register lets the next item enter
// while a finished result is still waiting. Writes to port A8, to FFFF and to
// FC-FF take effect for the very next item. Configuration writes are taken
// in any cycle (cfg_ready is always high) and should be made while idle.
module slot_select_memory_mapper_decoder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tuser fields from bit 0 up: op.
    // s_tdata fields from bit 0 up: address, data.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ssmm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [ssmm_pkg::S_TUSER_W-1:0]  s_tuser,
    // m_tuser fields from bit 0 up: target.
    // m_tdata fields from bit 0 up: target_address, write_data, internal_data, zero pad.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ssmm_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [ssmm_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssmm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssmm_pkg::*;

    logic                in_valid_reg;
    logic [OP_W-1:0]     in_op_reg;
    logic [ADDR_W-1:0]   in_addr_reg;
    logic [DATA_W-1:0]   in_data_reg;
    logic                out_valid_reg;
    ssmm_result_t        out_res_reg;

    logic                advance;
    ssmm_cfg_t           cfg;
    ssmm_state_t         state;
    ssmm_result_t        res;
    ssmm_update_t        upd;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.target;
    assign m_tdata  = {2'b00, out_res_reg.internal_data, out_res_reg.write_data,
                       out_res_reg.target_address};

    ssmm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssmm_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (advance),
        .upd    (upd),
        .state  (state)
    );

    ssmm_decode u_decode (
        .op      (in_op_reg),
        .address (in_addr_reg),
        .data    (in_data_reg),
        .cfg     (cfg),
        .state   (state),
        .res     (res),
        .upd     (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_addr_reg <= s_tdata[ADDR_W-1:0];
            in_data_reg <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

endmodule

// File: sv/ssmm_cfg.sv
// Configuration registers of the slot select memory mapper decoder.
module ssmm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssmm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssmm_pkg::CFG_DATA_W-1:0] cfg_data,
    output ssmm_pkg::ssmm_cfg_t            cfg
);
    import ssmm_pkg::*;

    ssmm_cfg_t cfg_reg;
    ssmm_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            priority if (cfg_index == CFG_SECOND_GEN)
            begin
                cfg_next.second_gen = cfg_data[0];
            end
            else if (cfg_index == CFG_BIOS_SIZE)
            begin
                cfg_next.bios_size = cfg_data[ROM_SIZE_W-1:0];
            end
            else if (cfg_index == CFG_RAM_SIZE)
            begin
                cfg_next.ram_size = cfg_data[RAM_SIZE_W-1:0];
            end
            else if (cfg_index == CFG_SUB_ROM_SIZE)
            begin
                cfg_next.sub_rom_size = cfg_data[ROM_SIZE_W-1:0];
            end
            else
            begin
                cfg_next = cfg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.second_gen   <= 1'b0;
            cfg_reg.bios_size    <= BIOS_SIZE_RESET;
            cfg_reg.ram_size     <= RAM_SIZE_RESET;
            cfg_reg.sub_rom_size <= SUB_ROM_SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/ssmm_state.sv
// Primary slot, secondary slot and mapper segment registers of the four pages.
module ssmm_state (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   upd_en,
    input  ssmm_pkg::ssmm_update_t upd,
    output ssmm_pkg::ssmm_state_t  state
);
    import ssmm_pkg::*;

    ssmm_state_t state_reg;
    ssmm_state_t state_next;

    assign state = state_reg;

    always_comb
    begin
        state_next = state_reg;
        if (upd_en)
        begin
            if (upd.wr_primary)
            begin
                state_next.primary = upd.value;
            end
            if (upd.wr_secondary)
            begin
                state_next.secondary = upd.value;
            end
            if (upd.wr_segment)
            begin
                state_next.segment[upd.seg_index] = upd.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/ssmm_decode.sv
// Combinational decode of one access into a target, an address and register updates.
module ssmm_decode (
    input  logic [ssmm_pkg::OP_W-1:0]   op,
    input  logic [ssmm_pkg::ADDR_W-1:0] address,
    input  logic [ssmm_pkg::DATA_W-1:0] data,
    input  ssmm_pkg::ssmm_cfg_t         cfg,
    input  ssmm_pkg::ssmm_state_t       state,
    output ssmm_pkg::ssmm_result_t      res,
    output ssmm_pkg::ssmm_update_t      upd
);
    import ssmm_pkg::*;

    logic [1:0]         page;
    logic [1:0]         prim;
    logic [1:0]         sec;
    logic [7:0]         port;
    logic               wr;
    logic [TADDR_W-1:0] ram_addr;
    logic               video_port;

    always_comb
    begin
        page       = address[15:14];
        prim       = state.primary[page];
        sec        = state.secondary[page];
        port       = address[7:0];
        wr         = (ssmm_op_t'(op) == OP_MEM_WRITE);
        video_port = (port >= PORT_VIDEO_FIRST) && (port <= PORT_VIDEO_LAST);
        if (cfg.second_gen)
        begin
            ram_addr = {state.segment[page], address[13:0]} & RAM_MASK;
        end
        else
        begin
            ram_addr = TADDR_W'(address) & RAM_MASK;
        end
    end

    always_comb
    begin
        res                = '0;
        res.target         = TGT_NONE;
        upd                = '0;
        upd.value          = data;
        upd.seg_index      = port[1:0];
        unique case (ssmm_op_t'(op))
            OP_MEM_READ, OP_MEM_WRITE:
            begin
                res.internal_data = wr ? '0 : OPEN_BUS;
                unique case (prim)
                    SLOT_BIOS:
                    begin
                        if (!wr && ({1'b0, address} < cfg.bios_size))
                        begin
                            res.target         = TGT_BIOS;
                            res.target_address = TADDR_W'(address);
                        end
                    end
                    SLOT_CART:
                    begin
                        res.target         = TGT_CART;
                        res.target_address = TADDR_W'(address);
                    end
                    SLOT_EXPANSION:
                    begin
                        res.target         = TGT_EXPANSION;
                        res.target_address = TADDR_W'(address);
                    end
                    SLOT_THREE:
                    begin
                        if (cfg.second_gen && (address == ADDR_SECONDARY_REG))
                        begin
                            // The secondary slot register reads back inverted.
                            if (wr)
                            begin
                                upd.wr_secondary = 1'b1;
                            end
                            else
                            begin
                                res.internal_data = ~state.secondary;
                            end
                        end
                        else if (sec == SUB_SLOT_RAM)
                        begin
                            if ({1'b0, ram_addr} < cfg.ram_size)
                            begin
                                res.target         = TGT_RAM;
                                res.target_address = ram_addr;
                            end
                        end
                        else if (sec == SUB_SLOT_SUB_ROM)
                        begin
                            if (!wr && (cfg.sub_rom_size != '0)
                                && ({1'b0, address} < cfg.sub_rom_size))
                            begin
                                res.target         = TGT_SUB_ROM;
                                res.target_address = TADDR_W'(address);
                            end
                        end
                    end
                    default:
                    begin
                        res.target = TGT_NONE;
                    end
                endcase
                if (res.target != TGT_NONE)
                begin
                    res.internal_data = '0;
                    res.write_data    = wr ? data : '0;
                end
            end
            OP_IO_IN:
            begin
                res.internal_data = OPEN_BUS;
                priority if (video_port)
                begin
                    res.target         = TGT_VIDEO;
                    res.target_address = TADDR_W'(port[1:0]);
                end
                else if (port == PORT_SOUND_READ)
                begin
                    res.target = TGT_SOUND_DATA;
                end
                else if (port == PORT_PRIMARY)
                begin
                    res.internal_data = state.primary;
                end
                else if (port == PORT_KEY_READ)
                begin
                    res.target = TGT_KEYBOARD;
                end
                else if ((port >= PORT_SEGMENT) && cfg.second_gen)
                begin
                    res.internal_data = state.segment[port[1:0]];
                end
                else
                begin
                    res.internal_data = OPEN_BUS;
                end
                if (res.target != TGT_NONE)
                begin
                    res.internal_data = '0;
                end
            end
            OP_IO_OUT:
            begin
                priority if (video_port)
                begin
                    res.target         = TGT_VIDEO;
                    res.target_address = TADDR_W'(port[1:0]);
                    res.write_data     = data;
                end
                else if (port == PORT_SOUND_SEL)
                begin
                    res.target     = TGT_SOUND_SEL;
                    res.write_data = data;
                end
                else if (port == PORT_SOUND_WRITE)
                begin
                    res.target     = TGT_SOUND_DATA;
                    res.write_data = data;
                end
                else if (port == PORT_PRIMARY)
                begin
                    upd.wr_primary = 1'b1;
                end
                else if (port == PORT_KEY_WRITE)
                begin
                    res.target     = TGT_KEYBOARD;
                    res.write_data = {4'h0, data[3:0]};
                end
                else if ((port >= PORT_SEGMENT) && cfg.second_gen)
                begin
                    upd.wr_segment = 1'b1;
                end
                else
                begin
                    res.target = TGT_NONE;
                end
            end
            default:
            begin
                res.target = TGT_NONE;
            end
        endcase
    end

endmodule

// File: sv/ssmm_checker.sv
// Port-level checks of the slot select memory mapper decoder and their binding.
module ssmm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ssmm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ssmm_pkg::M_TUSER_W-1:0] m_tuser
);
    import ssmm_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The input side only stalls while a result is waiting on the output side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // Readback data is only given when no device takes the access.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != TGT_NONE) |-> (m_tdata[37:30] == 8'h00))
        else $error("readback data present for a device access");

    // The keyboard receives four data bits only.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == TGT_KEYBOARD) |-> (m_tdata[29:26] == 4'h0))
        else $error("keyboard write data wider than four bits");

endmodule

bind slot_select_memory_mapper_decoder_unit ssmm_checker u_ssmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
